// File: hw/rtl/swerl_pkg.sv
// shared types and constants for the sliding window event rate limiter
// no dependencies
package swerl_pkg;

  typedef enum logic [1:0] {
    DEC_PASS     = 2'd0,
    DEC_MARKER   = 2'd1,
    DEC_SUPPRESS = 2'd2
  } decision_e;

  typedef enum logic {
    REG_IDX_WINDOW     = 1'b0,
    REG_IDX_MAX_EVENTS = 1'b1
  } reg_idx_e;

  localparam logic [31:0] WINDOW_MS_RESET  = 32'd60000;
  localparam logic [7:0]  MAX_EVENTS_RESET = 8'd120;
  localparam int unsigned APB_ADDR_W       = 3;

endpackage

// File: hw/rtl/swerl_if.sv
// valid/ready channel interfaces for event input and decision output
// depends on swerl_pkg
interface swerl_in_if;
  logic        valid;
  logic        ready;
  logic        is_counted;
  logic [63:0] now_ms;

  modport source (output valid, output is_counted, output now_ms, input ready);
  modport sink (input valid, input is_counted, input now_ms, output ready);
endinterface

interface swerl_out_if;
  logic                valid;
  logic                ready;
  swerl_pkg::decision_e decision;

  modport source (output valid, output decision, input ready);
  modport sink (input valid, input decision, output ready);
endinterface

// File: hw/rtl/sliding_window_event_rate_limiter.sv
// top level of the sliding window event rate limiter
// depends on swerl_pkg and the channel interfaces in swerl_if
// An event is taken while the block is idle and checked in the next cycle. Its decision is
// registered when the check ends. Each stored time that has aged out of the window is first
// dropped in the check state, one at a time from the oldest entry. The time memory has a
// registered read and is read at the oldest entry once per cycle while entries expire. One
// event is in work at a time. A decision waits in an output register, and the check holds
// while the previous decision is still waiting there. The next event is taken as soon as the
// block returns to idle. Diagnostic events (is_counted low) always pass. The time memory needs
// no clearing after reset, so events are taken as soon as reset is released.
module sliding_window_event_rate_limiter #(
  parameter int RING_DEPTH = 128
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  swerl_in_if.sink                             in_i,
  swerl_out_if.source                          out_o,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [swerl_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [31:0]                          pwdata,
  output logic [31:0]                          prdata,
  output logic                                 pready
);
  import swerl_pkg::*;

  localparam int IW = $clog2(RING_DEPTH);
  localparam int CW = $clog2(RING_DEPTH + 1);
  localparam int LW = (CW > 8) ? CW : 8;
  localparam int SW = CW + 1;
  localparam logic [LW-1:0] DEPTH_L = LW'(RING_DEPTH);
  localparam logic [SW-1:0] DEPTH_S = SW'(RING_DEPTH);
  localparam logic [IW-1:0] LAST_IDX = IW'(RING_DEPTH - 1);

  typedef enum logic {
    ST_IDLE,
    ST_CHECK
  } state_e;

  state_e      state_q, state_d;
  logic        counted_q, counted_d;
  logic [63:0] now_q, now_d;
  logic [IW-1:0] oldest_q, oldest_d;
  logic [CW-1:0] held_q, held_d;
  logic        marker_q, marker_d;
  logic        out_valid_q, out_valid_d;
  decision_e   out_dec_q, out_dec_d;
  logic [31:0] window_q, window_d;
  logic [7:0]  max_q, max_d;

  logic [63:0] mem [RING_DEPTH];
  logic [63:0] rd_data_q;

  logic [63:0]   age;
  logic          expired;
  logic          do_pop;
  logic          out_free;
  logic          held_zero;
  logic          marker_eff;
  logic [LW-1:0] limit;
  logic          has_room;
  logic [SW-1:0] slot_sum;
  logic [IW-1:0] wr_slot;
  logic          wr_en;
  logic [IW-1:0] oldest_inc;
  logic          cfg_wr;

  assign in_i.ready     = (state_q == ST_IDLE);
  assign out_o.valid    = out_valid_q;
  assign out_o.decision = out_dec_q;
  assign pready         = 1'b1;
  assign cfg_wr         = psel & penable & pwrite;

  always_comb begin
    case (reg_idx_e'(paddr[2]))
      REG_IDX_WINDOW:     prdata = window_q;
      REG_IDX_MAX_EVENTS: prdata = {24'd0, max_q};
      default:            prdata = '0;
    endcase
  end

  assign age        = now_q - rd_data_q;
  assign expired    = age >= {32'd0, window_q};
  assign held_zero  = (held_q == '0);
  assign do_pop     = (state_q == ST_CHECK) && counted_q && !held_zero && expired;
  assign out_free   = !out_valid_q || out_o.ready;
  assign limit      = (LW'(max_q) > DEPTH_L) ? DEPTH_L : LW'(max_q);
  assign has_room   = LW'(held_q) < limit;
  assign marker_eff = held_zero ? 1'b0 : marker_q;
  assign oldest_inc = (oldest_q == LAST_IDX) ? '0 : oldest_q + 1'b1;

  always_comb begin
    slot_sum = SW'(oldest_q) + SW'(held_q);
    if (slot_sum >= DEPTH_S) begin
      slot_sum = slot_sum - DEPTH_S;
    end
    wr_slot = slot_sum[IW-1:0];
  end

  assign wr_en = (state_q == ST_CHECK) && !do_pop && out_free && counted_q && has_room;

  always_comb begin
    state_d     = state_q;
    counted_d   = counted_q;
    now_d       = now_q;
    oldest_d    = oldest_q;
    held_d      = held_q;
    marker_d    = marker_q;
    out_valid_d = out_valid_q;
    out_dec_d   = out_dec_q;
    window_d    = window_q;
    max_d       = max_q;

    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    if (cfg_wr) begin
      case (reg_idx_e'(paddr[2]))
        REG_IDX_WINDOW:     window_d = pwdata;
        REG_IDX_MAX_EVENTS: max_d = pwdata[7:0];
        default:            ;
      endcase
    end

    case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          counted_d = in_i.is_counted;
          now_d     = in_i.now_ms;
          state_d   = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (do_pop) begin
          oldest_d = oldest_inc;
          held_d   = held_q - 1'b1;
        end else if (out_free) begin
          state_d     = ST_IDLE;
          out_valid_d = 1'b1;
          if (!counted_q) begin
            out_dec_d = DEC_PASS;
          end else if (has_room) begin
            held_d    = held_q + 1'b1;
            marker_d  = marker_eff;
            out_dec_d = DEC_PASS;
          end else if (!marker_eff) begin
            marker_d  = 1'b1;
            out_dec_d = DEC_MARKER;
          end else begin
            marker_d  = 1'b1;
            out_dec_d = DEC_SUPPRESS;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      counted_q   <= 1'b0;
      now_q       <= '0;
      oldest_q    <= '0;
      held_q      <= '0;
      marker_q    <= 1'b0;
      out_valid_q <= 1'b0;
      out_dec_q   <= DEC_PASS;
      window_q    <= WINDOW_MS_RESET;
      max_q       <= MAX_EVENTS_RESET;
    end else begin
      state_q     <= state_d;
      counted_q   <= counted_d;
      now_q       <= now_d;
      oldest_q    <= oldest_d;
      held_q      <= held_d;
      marker_q    <= marker_d;
      out_valid_q <= out_valid_d;
      out_dec_q   <= out_dec_d;
      window_q    <= window_d;
      max_q       <= max_d;
    end
  end

  // time memory, read at the next oldest entry every cycle
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_slot] <= now_q;
    end
    rd_data_q <= mem[oldest_d];
  end

endmodule

// File: hw/rtl/swerl_checker.sv
// port-level checks for the sliding window event rate limiter
// depends on swerl_pkg; bound to the top level at the end of this file
module swerl_checker (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_ready_i,
  input logic                 out_valid_i,
  input logic                 out_ready_i,
  input swerl_pkg::decision_e out_decision_i
);
  import swerl_pkg::*;

  a_dec_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_decision_i == DEC_PASS || out_decision_i == DEC_MARKER ||
                     out_decision_i == DEC_SUPPRESS))
    else $error("illegal decision code");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> (out_valid_i && $stable(out_decision_i)))
    else $error("stalled output transaction changed");

  a_one_in_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |=> !in_ready_i)
    else $error("new transaction taken while one is in work");

  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_i)
    else $error("output valid during reset");

endmodule

bind sliding_window_event_rate_limiter swerl_checker u_swerl_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_i.valid),
  .in_ready_i     (in_i.ready),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .out_decision_i (out_o.decision)
);

// File: tb/swerl_decision_checker.sv
`timescale 1ns / 100ps
// checker for the sliding window event rate limiter: watches the event, decision and apb
// ports, predicts each decision and compares it; depends on swerl_pkg and swerl_if
module swerl_decision_checker #(
  parameter int RING_DEPTH = 128
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  swerl_in_if                              ev_if,
  swerl_out_if                             dec_if,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic                             pready,
  input  logic [swerl_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [31:0]                      pwdata,
  output int                               pending_o,
  output int                               errors_o
);
  import swerl_pkg::*;

  logic [63:0] stamp_ring [RING_DEPTH];
  int          head_q;
  int          held_q;
  logic        marker_q;
  logic [31:0] window_q;
  logic [7:0]  limit_q;
  decision_e   pending_decisions[$];
  int          accepted_events;
  int          seen_decisions;
  int          mismatches = 0;

  assign pending_o = accepted_events - seen_decisions;
  assign errors_o  = mismatches;

  function automatic decision_e judge_event(input logic counted, input logic [63:0] t);
    int cap;
    if (!counted) return DEC_PASS;
    cap = (int'(limit_q) > RING_DEPTH) ? RING_DEPTH : int'(limit_q);
    while (held_q != 0 && (t - stamp_ring[head_q]) >= {32'b0, window_q}) begin
      head_q = (head_q + 1) % RING_DEPTH;
      held_q--;
    end
    if (held_q == 0) marker_q = 1'b0;
    if (held_q < cap) begin
      stamp_ring[(head_q + held_q) % RING_DEPTH] = t;
      held_q++;
      return DEC_PASS;
    end
    if (!marker_q) begin
      marker_q = 1'b1;
      return DEC_MARKER;
    end
    return DEC_SUPPRESS;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    decision_e want;
    if (!rst_ni) begin
      head_q = 0;
      held_q = 0;
      marker_q = 1'b0;
      window_q = WINDOW_MS_RESET;
      limit_q = MAX_EVENTS_RESET;
      pending_decisions.delete();
      accepted_events <= 0;
      seen_decisions <= 0;
    end else begin
      if (dec_if.valid && dec_if.ready) begin
        if (pending_decisions.size() == 0) begin
          $error("decision: expected none, actual %0d", dec_if.decision);
          mismatches++;
        end else begin
          want = pending_decisions.pop_front();
          if (dec_if.decision !== want) begin
            $error("decision: expected %0d, actual %0d", want, dec_if.decision);
            mismatches++;
          end
        end
        seen_decisions <= seen_decisions + 1;
      end
      if (ev_if.valid && ev_if.ready) begin
        pending_decisions.push_back(judge_event(ev_if.is_counted, ev_if.now_ms));
        accepted_events <= accepted_events + 1;
      end
      if (psel && penable && pwrite && pready) begin
        if (reg_idx_e'(paddr[APB_ADDR_W-1:2]) == REG_IDX_WINDOW) window_q = pwdata;
        else limit_q = pwdata[7:0];
      end
    end
  end

endmodule

// File: tb/tb_sliding_window_event_rate_limiter.sv
`timescale 1ns / 100ps
// top of the rate limiter testbench: clock, reset, apb writes, event and decision traffic
// depends on swerl_pkg, swerl_if, the block and swerl_decision_checker
module tb_sliding_window_event_rate_limiter;
  import swerl_pkg::*;

  localparam int RING_DEPTH     = 128;
  localparam int WATCHDOG_LIMIT = 5000;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [31:0]           pwdata;
  logic [31:0]           prdata;
  logic                  pready;
  int                    pending;
  int                    mismatches;
  int                    src_idle_pct = 0;
  int                    sink_stall_pct = 0;
  int                    holdoff_req = 0;
  int                    idle_cycles = 0;
  logic [63:0]           clock_ms = 64'd1000;

  swerl_in_if  ev_if ();
  swerl_out_if dec_if ();

  sliding_window_event_rate_limiter #(.RING_DEPTH(RING_DEPTH)) dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (ev_if),
    .out_o   (dec_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  swerl_decision_checker #(.RING_DEPTH(RING_DEPTH)) checker_i (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ev_if     (ev_if),
    .dec_if    (dec_if),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .pready    (pready),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .pending_o (pending),
    .errors_o  (mismatches)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // receiver, with an optional long hold-off requested by the stimulus
  initial begin
    int stall_left;
    stall_left = 0;
    dec_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (holdoff_req > 0) begin
        stall_left = holdoff_req;
        holdoff_req = 0;
      end
      if (stall_left > 0) begin
        dec_if.ready <= 1'b0;
        stall_left--;
      end else begin
        dec_if.ready <= ($urandom_range(99) >= sink_stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((ev_if.valid && ev_if.ready) || (dec_if.valid && dec_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("sliding_window_event_rate_limiter verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // mostly advancing time, with jumps and steps backwards as noise
  function automatic logic [63:0] next_time(input int unsigned step_max, input int noise_pct);
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < noise_pct / 2) clock_ms = rand64();
    else if (roll < noise_pct) clock_ms = clock_ms - $urandom_range(50);
    else clock_ms = clock_ms + $urandom_range(step_max);
    return clock_ms;
  endfunction

  task automatic send_event(input logic counted, input logic [63:0] t);
    while ($urandom_range(99) < src_idle_pct) begin
      ev_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    ev_if.valid <= 1'b1;
    ev_if.is_counted <= counted;
    ev_if.now_ms <= t;
    do @(posedge clk_i); while (!ev_if.ready);
  endtask

  task automatic settle();
    ev_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  task automatic reg_write(input reg_idx_e idx, input logic [31:0] value);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic set_limits(input logic [31:0] window_ms, input logic [7:0] max_events);
    reg_write(REG_IDX_WINDOW, window_ms);
    reg_write(REG_IDX_MAX_EVENTS, {24'b0, max_events});
  endtask

  task automatic run_batch(input logic [31:0] window_ms, input logic [7:0] max_events,
                           input int count, input int unsigned step_max,
                           input int counted_pct, input int noise_pct);
    logic [63:0] t;
    set_limits(window_ms, max_events);
    for (int i = 0; i < count; i++) begin
      t = next_time(step_max, noise_pct);
      send_event($urandom_range(99) < counted_pct, t);
    end
    settle();
  endtask

  initial begin
    int src_pcts[4];
    int sink_pcts[4];
    src_pcts = '{0, 61, 0, 10};
    sink_pcts = '{0, 0, 61, 10};
    rst_ni = 1'b0;
    ev_if.valid <= 1'b0;
    ev_if.is_counted <= 1'b0;
    ev_if.now_ms <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset limits, extreme times, wrap of the age
    send_event(1'b0, 64'd0);
    send_event(1'b0, '1);
    send_event(1'b1, 64'd0);
    send_event(1'b1, '1);
    send_event(1'b1, 64'd5);
    send_event(1'b1, 64'd3);
    settle();
    // limit lowered below the held count
    set_limits(32'd60000, 8'd2);
    send_event(1'b1, 64'd10);
    send_event(1'b1, 64'd11);
    send_event(1'b0, 64'd12);
    settle();
    set_limits(32'd1, 8'd2);
    send_event(1'b1, 64'd20);
    send_event(1'b1, 64'd20);
    send_event(1'b1, 64'd20);
    send_event(1'b1, 64'd21);
    settle();
    // zero window and zero limit
    set_limits(32'd0, 8'd0);
    send_event(1'b1, 64'd30);
    send_event(1'b1, 64'd30);
    send_event(1'b0, 64'd30);
    settle();
    // widest window, limit above the ring depth
    set_limits('1, 8'd255);
    send_event(1'b1, 64'd100);
    send_event(1'b1, 64'd100 + 64'hFFFF_FFFE);
    send_event(1'b1, 64'd100 + 64'hFFFF_FFFF);
    settle();

    // long receiver hold-off while events keep coming
    clock_ms = 64'd5000;
    set_limits(32'd60000, 8'd4);
    holdoff_req = 400;
    for (int i = 0; i < 24; i++) send_event(1'b1, next_time(1, 0));
    settle();

    for (int p = 0; p < 4; p++) begin
      src_idle_pct = src_pcts[p];
      sink_stall_pct = sink_pcts[p];
      run_batch($urandom_range(40, 1), 8'($urandom_range(8, 1)), 80, 6, 90, 8);
      run_batch(($urandom_range(1) != 0) ? 32'hFFFF_FFFF : $urandom_range(32'hFFFF_FFFF, 32'h10_0000),
                8'($urandom_range(255, 128)), 160, 2, 95, 0);
      run_batch($urandom, 8'($urandom_range(255)), 45, 32'hFFFF_FFFF, 85, 10);
    end

    settle();
    repeat (200) @(posedge clk_i);
    if (mismatches == 0 && pending == 0) begin
      $display("sliding_window_event_rate_limiter verification clean");
    end else begin
      $display("sliding_window_event_rate_limiter verification failed");
    end
    $finish;
  end

endmodule
